@@ design/lsc_pkg.sv @@
package lsc_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP    = 2'd3;

    localparam int RESET_LEFT   = 0;
    localparam int RESET_BOTTOM = 0;
    localparam int RESET_RIGHT  = 639;
    localparam int RESET_TOP    = 479;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODE,
        ST_SETUP,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_APPLY,
        ST_FINISH
    } lsc_state_t;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_BOTTOM,
        EDGE_TOP
    } lsc_edge_t;

endpackage

@@ design/lsc_div.sv @@
module lsc_div #(
    parameter int DIVIDEND_W = 34,
    parameter int DIVISOR_W  = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/line_segment_clipper_top.sv @@
// each pass takes the outcodes, then moves the first endpoint onto each window edge
// it lies beyond, one edge at a time (one multiply, then a shared divider giving
// one quotient bit per cycle)
// throughput: one segment at a time, the next is taken once the result is in the output register
// the output register lets a new segment start while the last result waits for a transfer
// reset: asynchronous active low, window returns to 0, 0, 639, 479 and no result is pending
module line_segment_clipper_top #(
    parameter int COORD_BITS = 16,
    parameter int MAX_PASSES = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lsc_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [COORD_BITS-1:0]                   cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [((4*COORD_BITS+8)/8)*8-1:0]       m_axis_tdata
);

    localparam int CB     = COORD_BITS;
    localparam int DW     = 2 * (CB + 1);
    localparam int PASS_W = $clog2(MAX_PASSES + 1);
    localparam int OUT_W  = ((4*COORD_BITS+8)/8)*8;

    lsc_pkg::lsc_state_t    state_reg;
    lsc_pkg::lsc_state_t    state_next;
    lsc_pkg::lsc_edge_t     low_sel;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;

    logic signed [CB-1:0] wl_reg, wb_reg, wr_reg, wt_reg;
    logic signed [CB-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CB-1:0] x1_next, y1_next, x2_next, y2_next;
    logic [3:0]           b_reg, b_next;
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [CB:0]          ma_reg, mb_reg, mc_reg;
    logic                 neg_reg, czero_reg;
    logic [DW-1:0]        prod_reg;
    logic [DW-1:0]        quotient;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_vis_reg, out_vis_next;
    logic signed [CB-1:0] out_x1_reg, out_y1_reg, out_x2_reg, out_y2_reg;
    logic signed [CB-1:0] out_x1_next, out_y1_next, out_x2_next, out_y2_next;

    logic [3:0]           c1, c2;
    logic                 is_x;
    logic signed [CB-1:0] edge_val;
    logic signed [CB:0]   num_a, num_b, den_c;
    logic [CB:0]          qc;
    logic signed [CB+1:0] offs, base, sum;
    logic signed [CB-1:0] sat_val;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == lsc_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-4*CB-1){1'b0}}, out_y2_reg, out_x2_reg, out_y1_reg,
                            out_x1_reg, out_vis_reg};

    // outcodes: bit0 left, bit1 right, bit2 bottom, bit3 top
    always_comb
    begin
        c1 = {y1_reg > wt_reg, y1_reg < wb_reg, x1_reg > wr_reg, x1_reg < wl_reg};
        c2 = {y2_reg > wt_reg, y2_reg < wb_reg, x2_reg > wr_reg, x2_reg < wl_reg};
    end

    always_comb
    begin
        if (b_reg[0])
        begin
            low_sel = lsc_pkg::EDGE_LEFT;
        end
        else if (b_reg[1])
        begin
            low_sel = lsc_pkg::EDGE_RIGHT;
        end
        else if (b_reg[2])
        begin
            low_sel = lsc_pkg::EDGE_BOTTOM;
        end
        else
        begin
            low_sel = lsc_pkg::EDGE_TOP;
        end
    end

    // edge move operands and result
    always_comb
    begin
        case (low_sel)
            lsc_pkg::EDGE_LEFT:
            begin
                edge_val = wl_reg;
                is_x     = 1'b1;
            end
            lsc_pkg::EDGE_RIGHT:
            begin
                edge_val = wr_reg;
                is_x     = 1'b1;
            end
            lsc_pkg::EDGE_BOTTOM:
            begin
                edge_val = wb_reg;
                is_x     = 1'b0;
            end
            default:
            begin
                edge_val = wt_reg;
                is_x     = 1'b0;
            end
        endcase
        if (is_x)
        begin
            num_a = {edge_val[CB-1], edge_val} - {x1_reg[CB-1], x1_reg};
            num_b = {y2_reg[CB-1], y2_reg} - {y1_reg[CB-1], y1_reg};
            den_c = {x2_reg[CB-1], x2_reg} - {x1_reg[CB-1], x1_reg};
            base  = {{2{y1_reg[CB-1]}}, y1_reg};
        end
        else
        begin
            num_a = {edge_val[CB-1], edge_val} - {y1_reg[CB-1], y1_reg};
            num_b = {x2_reg[CB-1], x2_reg} - {x1_reg[CB-1], x1_reg};
            den_c = {y2_reg[CB-1], y2_reg} - {y1_reg[CB-1], y1_reg};
            base  = {{2{x1_reg[CB-1]}}, x1_reg};
        end
        // quotients at or above 2^CB saturate the sum either way
        if (|quotient[DW-1:CB])
        begin
            qc = {1'b1, {CB{1'b0}}};
        end
        else
        begin
            qc = {1'b0, quotient[CB-1:0]};
        end
        if (czero_reg)
        begin
            offs = '0;
        end
        else if (neg_reg)
        begin
            offs = -$signed({1'b0, qc});
        end
        else
        begin
            offs = $signed({1'b0, qc});
        end
        sum = base + offs;
        if ((sum[CB+1] == sum[CB]) && (sum[CB] == sum[CB-1]))
        begin
            sat_val = sum[CB-1:0];
        end
        else if (sum[CB+1])
        begin
            sat_val = {1'b1, {(CB-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(CB-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        b_next         = b_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        out_vis_next   = out_vis_reg;
        out_x1_next    = out_x1_reg;
        out_y1_next    = out_y1_reg;
        out_x2_next    = out_x2_reg;
        out_y2_next    = out_y2_reg;
        div_start      = 1'b0;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            lsc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x1_next    = s_axis_tdata[CB-1:0];
                    y1_next    = s_axis_tdata[2*CB-1:CB];
                    x2_next    = s_axis_tdata[3*CB-1:2*CB];
                    y2_next    = s_axis_tdata[4*CB-1:3*CB];
                    pass_next  = '0;
                    state_next = lsc_pkg::ST_CODE;
                end
            end
            lsc_pkg::ST_CODE:
            begin
                if (pass_reg == PASS_W'(MAX_PASSES))
                begin
                    b_next     = 4'b1111;
                    state_next = lsc_pkg::ST_FINISH;
                end
                else if ((c1 | c2) == 4'b0000)
                begin
                    b_next     = 4'b0000;
                    state_next = lsc_pkg::ST_FINISH;
                end
                else if ((c1 & c2) != 4'b0000)
                begin
                    b_next     = 4'b1111;
                    state_next = lsc_pkg::ST_FINISH;
                end
                else
                begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = lsc_pkg::ST_SETUP;
                    if (c1 == 4'b0000)
                    begin
                        x1_next = x2_reg;
                        y1_next = y2_reg;
                        x2_next = x1_reg;
                        y2_next = y1_reg;
                        b_next  = c2;
                    end
                    else
                    begin
                        b_next = c1;
                    end
                end
            end
            lsc_pkg::ST_SETUP:
            begin
                state_next = lsc_pkg::ST_MUL;
            end
            lsc_pkg::ST_MUL:
            begin
                state_next = lsc_pkg::ST_START;
            end
            lsc_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = lsc_pkg::ST_DIV;
            end
            lsc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lsc_pkg::ST_APPLY;
                end
            end
            lsc_pkg::ST_APPLY:
            begin
                if (is_x)
                begin
                    y1_next = sat_val;
                    x1_next = edge_val;
                end
                else
                begin
                    x1_next = sat_val;
                    y1_next = edge_val;
                end
                b_next = b_reg & ~(4'b0001 << low_sel);
                if (b_next == 4'b0000)
                begin
                    state_next = lsc_pkg::ST_CODE;
                end
                else
                begin
                    state_next = lsc_pkg::ST_SETUP;
                end
            end
            lsc_pkg::ST_FINISH:
            begin
                // b is all ones for a rejection, zero for an accepted segment
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_vis_next   = (b_reg == 4'b0000);
                    if (b_reg == 4'b0000)
                    begin
                        out_x1_next = x1_reg;
                        out_y1_next = y1_reg;
                        out_x2_next = x2_reg;
                        out_y2_next = y2_reg;
                    end
                    else
                    begin
                        out_x1_next = '0;
                        out_y1_next = '0;
                        out_x2_next = '0;
                        out_y2_next = '0;
                    end
                    state_next = lsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsc_pkg::ST_IDLE;
            b_reg         <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_reg         <= b_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= CB'(lsc_pkg::RESET_LEFT);
            wb_reg <= CB'(lsc_pkg::RESET_BOTTOM);
            wr_reg <= CB'(lsc_pkg::RESET_RIGHT);
            wt_reg <= CB'(lsc_pkg::RESET_TOP);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lsc_pkg::REG_LEFT:   wl_reg <= cfg_data;
                lsc_pkg::REG_BOTTOM: wb_reg <= cfg_data;
                lsc_pkg::REG_RIGHT:  wr_reg <= cfg_data;
                lsc_pkg::REG_TOP:    wt_reg <= cfg_data;
                default:             wl_reg <= wl_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        x2_reg      <= x2_next;
        y2_reg      <= y2_next;
        out_vis_reg <= out_vis_next;
        out_x1_reg  <= out_x1_next;
        out_y1_reg  <= out_y1_next;
        out_x2_reg  <= out_x2_next;
        out_y2_reg  <= out_y2_next;
        if (state_reg == lsc_pkg::ST_SETUP)
        begin
            ma_reg    <= num_a[CB] ? (CB+1)'(-num_a) : num_a;
            mb_reg    <= num_b[CB] ? (CB+1)'(-num_b) : num_b;
            mc_reg    <= den_c[CB] ? (CB+1)'(-den_c) : den_c;
            neg_reg   <= num_a[CB] ^ num_b[CB] ^ den_c[CB];
            czero_reg <= (den_c == '0);
        end
        if (state_reg == lsc_pkg::ST_MUL)
        begin
            prod_reg <= ma_reg * mb_reg;
        end
    end

    lsc_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (CB + 1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mc_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_vis_reg) |->
        (out_x1_reg == '0 && out_y1_reg == '0 && out_x2_reg == '0 && out_y2_reg == '0))
        else $error("rejected segment carries nonzero coordinates");

    a_accept_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_vis_reg) |->
        (out_x1_reg >= wl_reg && out_x1_reg <= wr_reg && out_y1_reg >= wb_reg &&
         out_y1_reg <= wt_reg && out_x2_reg >= wl_reg && out_x2_reg <= wr_reg &&
         out_y2_reg >= wb_reg && out_y2_reg <= wt_reg))
        else $error("accepted segment lies outside the window");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= PASS_W'(MAX_PASSES))
        else $error("pass count beyond limit");

    a_apply_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsc_pkg::ST_APPLY) |->
        (b_reg != 4'b0000 && !div_busy && $past(div_done)))
        else $error("edge move applied without a finished division");
`endif

endmodule

@@ dv/line_segment_clipper_top_tb.sv @@
module line_segment_clipper_top_tb;

    localparam int COORD_BITS = 16;
    localparam int MAX_PASSES = 8;
    localparam int IN_W = ((4*COORD_BITS+7)/8)*8;
    localparam int OUT_W = ((4*COORD_BITS+8)/8)*8;
    localparam int COORD_MAX = 2**(COORD_BITS-1) - 1;
    localparam int COORD_MIN = -(2**(COORD_BITS-1));
    localparam int EDGE_MOVE_CYCLES = 2*COORD_BITS + 7;
    localparam int LAT_MAX = 3 + MAX_PASSES*(1 + 4*EDGE_MOVE_CYCLES);
    localparam int ITEMS_PER_PHASE = 85;

    typedef struct {
        int l;
        int b;
        int r;
        int t;
    } win_t;

    typedef struct {
        int x1;
        int y1;
        int x2;
        int y2;
    } seg_t;

    typedef struct {
        bit vis;
        int x1;
        int y1;
        int x2;
        int y2;
    } clip_t;

    typedef struct {
        bit    set_win;
        win_t  win;
        seg_t  seg;
        bit    known;
        clip_t result;
    } row_t;

    typedef enum {
        WIN_FULL,
        WIN_ORDERED,
        WIN_POINT,
        WIN_INVERTED,
        WIN_RESET
    } win_kind_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lsc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [COORD_BITS-1:0]           cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [IN_W-1:0]                 s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [OUT_W-1:0]                m_axis_tdata;

    win_t  clip_win;
    clip_t results_due [$];
    int    mismatch_count;
    bit    no_idle;

    row_t plan [24] = '{
        '{1'b0, '{0, 0, 0, 0}, '{10, 20, 600, 400}, 1'b1, '{1'b1, 10, 20, 600, 400}},
        '{1'b0, '{0, 0, 0, 0}, '{0, 0, 639, 479}, 1'b1, '{1'b1, 0, 0, 639, 479}},
        '{1'b0, '{0, 0, 0, 0}, '{-5, 10, -100, 200}, 1'b1, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{100, 500, 300, 900}, 1'b1, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{-32768, -32768, -32768, -32768}, 1'b1, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{32767, 32767, 32767, 32767}, 1'b1, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{-32768, -32768, 32767, 32767}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{-100, 100, 800, 100}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{320, -50, 320, 600}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        // left move lands on the far endpoint's y, bottom move then divides by zero
        '{1'b0, '{0, 0, 0, 0}, '{-10, -1, 0, 5}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{700, 240, 320, 240}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{-50, -50, 100, 600}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{-1, 240, -1, 240}, 1'b1, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{639, 479, 639, 479}, 1'b1, '{1'b1, 639, 479, 639, 479}},
        '{1'b1, '{-32768, -32768, 32767, 32767}, '{-32768, 32767, 32767, -32768},
            1'b1, '{1'b1, -32768, 32767, 32767, -32768}},
        '{1'b0, '{0, 0, 0, 0}, '{32767, -32768, -32768, 32767},
            1'b1, '{1'b1, 32767, -32768, -32768, 32767}},
        // inverted window
        '{1'b1, '{100, 100, 0, 0}, '{50, 50, 50, 50}, 1'b1, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{-200, -300, 400, 500}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{150, -50, -40, 220}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b1, '{32767, 32767, -32768, -32768}, '{0, 0, 10, 20}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{32767, -32768, -32768, 32767}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        // single point window
        '{1'b1, '{5, 5, 5, 5}, '{0, 0, 10, 10}, 1'b0, '{1'b0, 0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{5, 5, 5, 5}, 1'b1, '{1'b1, 5, 5, 5, 5}},
        '{1'b0, '{0, 0, 0, 0}, '{-32768, 32767, 32767, -32768}, 1'b0, '{1'b0, 0, 0, 0, 0}}
    };

    win_kind_t phase_plan [6] = '{
        WIN_FULL, WIN_ORDERED, WIN_POINT, WIN_INVERTED, WIN_ORDERED, WIN_RESET
    };

    line_segment_clipper_top #(
        .COORD_BITS (COORD_BITS),
        .MAX_PASSES (MAX_PASSES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [3:0] region(longint x, longint y);
        logic [3:0] code;
        code = 4'b0000;
        if (x < clip_win.l) code[0] = 1'b1;
        if (x > clip_win.r) code[1] = 1'b1;
        if (y < clip_win.b) code[2] = 1'b1;
        if (y > clip_win.t) code[3] = 1'b1;
        return code;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // truncating toward zero, zero divisor gives no offset
    function automatic longint edge_offset(longint num, longint dir, longint den);
        if (den == 0) return 0;
        return (num * dir) / den;
    endfunction

    function automatic clip_t clip_segment(seg_t seg);
        clip_t      res;
        longint     x1, y1, x2, y2, t;
        logic [3:0] c1, c2;
        res = '{1'b0, 0, 0, 0, 0};
        x1 = seg.x1;
        y1 = seg.y1;
        x2 = seg.x2;
        y2 = seg.y2;
        for (int pass = 0; pass < MAX_PASSES; pass++)
        begin
            c1 = region(x1, y1);
            c2 = region(x2, y2);
            if ((c1 | c2) == 4'b0000)
            begin
                res = '{1'b1, int'(x1), int'(y1), int'(x2), int'(y2)};
                return res;
            end
            if ((c1 & c2) != 4'b0000) return res;
            if (c1 == 4'b0000)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
                c1 = c2;
            end
            if (c1[0])
            begin
                y1 = clamp_coord(y1 + edge_offset(clip_win.l - x1, y2 - y1, x2 - x1));
                x1 = clip_win.l;
            end
            if (c1[1])
            begin
                y1 = clamp_coord(y1 + edge_offset(clip_win.r - x1, y2 - y1, x2 - x1));
                x1 = clip_win.r;
            end
            if (c1[2])
            begin
                x1 = clamp_coord(x1 + edge_offset(clip_win.b - y1, x2 - x1, y2 - y1));
                y1 = clip_win.b;
            end
            if (c1[3])
            begin
                x1 = clamp_coord(x1 + edge_offset(clip_win.t - y1, x2 - x1, y2 - y1));
                y1 = clip_win.t;
            end
        end
        // passes exhausted
        return res;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, 2**COORD_BITS - 1)) + COORD_MIN;
    endfunction

    function automatic int pick_coord(int lo, int hi);
        int a, b, span, v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a + 16;
        case ($urandom_range(0, 9))
            0, 1: v = full_coord();
            2: v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            3: v = ($urandom_range(0, 1) ? a : b) + int'($urandom_range(0, 2)) - 1;
            default: v = a - span / 2 + int'($urandom_range(0, 2 * span));
        endcase
        return int'(clamp_coord(v));
    endfunction

    function automatic seg_t random_segment();
        seg_t seg;
        seg.x1 = pick_coord(clip_win.l, clip_win.r);
        seg.y1 = pick_coord(clip_win.b, clip_win.t);
        seg.x2 = pick_coord(clip_win.l, clip_win.r);
        seg.y2 = pick_coord(clip_win.b, clip_win.t);
        return seg;
    endfunction

    function automatic win_t pick_window(win_kind_t kind);
        win_t w;
        int   xa, xb, ya, yb, xlo, xhi, ylo, yhi;
        xa = full_coord();
        xb = full_coord();
        ya = full_coord();
        yb = full_coord();
        xlo = (xa < xb) ? xa : xb;
        xhi = (xa < xb) ? xb : xa;
        ylo = (ya < yb) ? ya : yb;
        yhi = (ya < yb) ? yb : ya;
        case (kind)
            WIN_FULL:     w = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX};
            WIN_ORDERED:  w = '{xlo, ylo, xhi, yhi};
            WIN_POINT:    w = '{xa / 64, ya / 64, xa / 64, ya / 64};
            WIN_INVERTED: w = '{xhi, yhi, xlo, ylo};
            default:      w = '{lsc_pkg::RESET_LEFT, lsc_pkg::RESET_BOTTOM,
                                lsc_pkg::RESET_RIGHT, lsc_pkg::RESET_TOP};
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 200)
            $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [OUT_W-1:0] data);
        clip_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch("result with nothing pending", data[0], 0);
            return;
        end
        want = results_due.pop_front();
        if (data[0] != want.vis)
            report_mismatch("visible", data[0], want.vis);
        if ($signed(data[1 +: COORD_BITS]) != want.x1)
            report_mismatch("clip_start_x", $signed(data[1 +: COORD_BITS]), want.x1);
        if ($signed(data[1+COORD_BITS +: COORD_BITS]) != want.y1)
            report_mismatch("clip_start_y", $signed(data[1+COORD_BITS +: COORD_BITS]), want.y1);
        if ($signed(data[1+2*COORD_BITS +: COORD_BITS]) != want.x2)
            report_mismatch("clip_end_x", $signed(data[1+2*COORD_BITS +: COORD_BITS]), want.x2);
        if ($signed(data[1+3*COORD_BITS +: COORD_BITS]) != want.y2)
            report_mismatch("clip_end_y", $signed(data[1+3*COORD_BITS +: COORD_BITS]), want.y2);
    endtask

    task automatic write_reg(input logic [lsc_pkg::CFG_INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= COORD_BITS'(value);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            lsc_pkg::REG_LEFT:   clip_win.l = value;
            lsc_pkg::REG_BOTTOM: clip_win.b = value;
            lsc_pkg::REG_RIGHT:  clip_win.r = value;
            lsc_pkg::REG_TOP:    clip_win.t = value;
            default:    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_window(input win_t w);
        write_reg(lsc_pkg::REG_LEFT, w.l);
        write_reg(lsc_pkg::REG_BOTTOM, w.b);
        write_reg(lsc_pkg::REG_RIGHT, w.r);
        write_reg(lsc_pkg::REG_TOP, w.t);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic send_segment(input seg_t seg, input bit known, input clip_t given);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {COORD_BITS'(seg.y2), COORD_BITS'(seg.x2),
                          COORD_BITS'(seg.y1), COORD_BITS'(seg.x1)};
        do @(posedge clk); while (!s_axis_tready);
        // transfer taken, window is stable while segments are in flight
        results_due.push_back(known ? given : clip_segment(seg));
    endtask

    initial
    begin : result_monitor
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tdata);
                stall = draw_gap();
            end
            @(negedge clk);
            m_axis_tready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    initial
    begin : stimulus
        clip_t none;
        none = '{1'b0, 0, 0, 0, 0};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_count = 0;
        no_idle = 1'b0;
        clip_win = '{lsc_pkg::RESET_LEFT, lsc_pkg::RESET_BOTTOM,
                     lsc_pkg::RESET_RIGHT, lsc_pkg::RESET_TOP};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].set_win)
            begin
                drain_results();
                write_window(plan[i].win);
            end
            send_segment(plan[i].seg, plan[i].known, plan[i].result);
        end

        foreach (phase_plan[p])
        begin
            drain_results();
            write_window(pick_window(phase_plan[p]));
            no_idle = (p == 1);
            repeat (ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 39) == 0)
                    drain_results();
                send_segment(random_segment(), 1'b0, none);
            end
        end

        drain_results();
        repeat (LAT_MAX + 16) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/lsc_pkg.sv
design/lsc_div.sv
design/line_segment_clipper_top.sv
dv/line_segment_clipper_top_tb.sv
